/* rtl/mcr_pkg.sv */
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Command codes, algorithm constants and sizes shared by the rasterizer files.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

	// Command encoding, only the low bit of the command field is used.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Constants of the midpoint decision update.
	localparam int DEC_INIT     = 3;
	localparam int DEC_ADD_DIAG = 10;
	localparam int DEC_ADD_AXIS = 6;

	// Eight mirrored points per iteration.
	localparam int NUM_OCTANTS = 8;
	localparam int OCT_BITS    = $clog2(NUM_OCTANTS);

	// Reset value of the outline color register.
	localparam logic [31:0] COLOR_RESET = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

/* rtl/mcr_fifo.sv */
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer job queue
// Two-entry queue that decouples the decision front end from the point emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_fifo #(
	parameter int WIDTH = 45
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  not_full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// Storage entries carry payload only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/mcr_front.sv */
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer front end
// Accepts start and step commands, runs the decision update and queues a job.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_front #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    command,
	input  wire logic [COORD_BITS-1:0]   center_x,
	input  wire logic [COORD_BITS-1:0]   center_y,
	input  wire logic [COORD_BITS-1:0]   radius,
	input  wire logic                    job_ready,
	output logic                         job_push,
	output logic [COORD_BITS-1:0]        job_cx,
	output logic [COORD_BITS-1:0]        job_cy,
	output logic signed [COORD_BITS:0]   job_x,
	output logic signed [COORD_BITS:0]   job_y,
	output logic                         job_fin
);

	localparam int OFF_BITS = COORD_BITS + 1;
	localparam int DEC_BITS = COORD_BITS + 4;

	logic [COORD_BITS-1:0]      held_cx_q;
	logic [COORD_BITS-1:0]      held_cy_q;
	logic signed [OFF_BITS-1:0] offset_x_q;
	logic signed [OFF_BITS-1:0] offset_y_q;
	logic signed [DEC_BITS-1:0] decision_q;
	logic                       drawing_q;

	logic                       accept;
	logic                       is_start;
	logic                       step_run;
	logic                       dec_pos;
	logic signed [OFF_BITS-1:0] y_step;
	logic signed [OFF_BITS-1:0] x_step;
	logic signed [DEC_BITS-1:0] xe;
	logic signed [DEC_BITS-1:0] term;
	logic signed [DEC_BITS-1:0] d_step;
	logic signed [DEC_BITS-1:0] d_start;

	assign in_ready = job_ready;
	assign accept   = in_valid && in_ready;
	assign is_start = (command == mcr_pkg::CMD_START);

	// One loop iteration of the midpoint algorithm.
	always_comb begin
		step_run = drawing_q && !(offset_y_q < offset_x_q);
		dec_pos  = (decision_q > 0);
		y_step   = dec_pos ? (offset_y_q - OFF_BITS'(1)) : offset_y_q;
		x_step   = offset_x_q + OFF_BITS'(1);
		xe       = {{(DEC_BITS - OFF_BITS){offset_x_q[OFF_BITS-1]}}, offset_x_q};
		if (dec_pos) begin
			term = xe - {{(DEC_BITS - OFF_BITS){y_step[OFF_BITS-1]}}, y_step};
			d_step = decision_q + {term[DEC_BITS-3:0], 2'b00}
				+ DEC_BITS'(mcr_pkg::DEC_ADD_DIAG);
		end else begin
			term = xe;
			d_step = decision_q + {term[DEC_BITS-3:0], 2'b00}
				+ DEC_BITS'(mcr_pkg::DEC_ADD_AXIS);
		end
		d_start = DEC_BITS'(mcr_pkg::DEC_INIT) - {3'b000, radius, 1'b0};
	end

	// Job handed to the emitter.
	always_comb begin
		job_push = accept;
		if (is_start) begin
			job_cx  = center_x;
			job_cy  = center_y;
			job_x   = '0;
			job_y   = {1'b0, radius};
			job_fin = 1'b0;
		end else begin
			job_cx  = held_cx_q;
			job_cy  = held_cy_q;
			job_x   = x_step;
			job_y   = y_step;
			job_fin = !step_run;
		end
	end

	// Circle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cx_q  <= '0;
			held_cy_q  <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
			decision_q <= '0;
			drawing_q  <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				held_cx_q  <= center_x;
				held_cy_q  <= center_y;
				offset_x_q <= '0;
				offset_y_q <= {1'b0, radius};
				decision_q <= d_start;
				drawing_q  <= 1'b1;
			end else if (step_run) begin
				offset_x_q <= x_step;
				offset_y_q <= y_step;
				decision_q <= d_step;
			end else begin
				drawing_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/mcr_back.sv */
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer point emitter
// Takes queued jobs and emits the eight mirrored points or one status result.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_back #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        job_avail,
	output logic                             job_pop,
	input  wire logic [COORD_BITS-1:0]       job_cx,
	input  wire logic [COORD_BITS-1:0]       job_cy,
	input  wire logic signed [COORD_BITS:0]  job_x,
	input  wire logic signed [COORD_BITS:0]  job_y,
	input  wire logic                        job_fin,
	input  wire logic [31:0]                 color,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [COORD_BITS+1:0]     pixel_x,
	output logic signed [COORD_BITS+1:0]     pixel_y,
	output logic [31:0]                      pixel_color,
	output logic                             pixel_valid,
	output logic                             last_of_step,
	output logic                             finished
);

	localparam int OUT_BITS = COORD_BITS + 2;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_EMIT = 2'b10
	} bk_state_t;

	bk_state_t                          state_q;
	logic [mcr_pkg::OCT_BITS-1:0]       oct_q;
	logic [COORD_BITS-1:0]              cx_q;
	logic [COORD_BITS-1:0]              cy_q;
	logic signed [COORD_BITS:0]         x_q;
	logic signed [COORD_BITS:0]         y_q;
	logic                               fin_q;
	logic                               ovalid_q;

	logic                               can_load;
	logic                               emit;
	logic                               last_pt;
	logic signed [COORD_BITS:0]         a_off;
	logic signed [COORD_BITS:0]         b_off;
	logic signed [OUT_BITS-1:0]         a_ext;
	logic signed [OUT_BITS-1:0]         b_ext;
	logic signed [OUT_BITS-1:0]         px;
	logic signed [OUT_BITS-1:0]         py;

	assign out_valid = ovalid_q;
	assign can_load  = !ovalid_q || out_ready;
	assign emit      = (state_q == BK_EMIT) && can_load;
	assign last_pt   = fin_q || (oct_q == mcr_pkg::OCT_BITS'(mcr_pkg::NUM_OCTANTS - 1));
	assign job_pop   = job_avail && ((state_q == BK_IDLE) || (emit && last_pt));

	// Octant mirroring: bit 2 swaps the axes, bits 0 and 1 negate them.
	always_comb begin
		a_off = oct_q[2] ? y_q : x_q;
		b_off = oct_q[2] ? x_q : y_q;
		a_ext = {a_off[COORD_BITS], a_off};
		b_ext = {b_off[COORD_BITS], b_off};
		px = oct_q[0] ? ({2'b00, cx_q} - a_ext) : ({2'b00, cx_q} + a_ext);
		py = oct_q[1] ? ({2'b00, cy_q} - b_ext) : ({2'b00, cy_q} + b_ext);
	end

	// Sequencer over the points of the current job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			oct_q   <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (job_pop) begin
						state_q <= BK_EMIT;
						oct_q   <= '0;
					end
				end
				BK_EMIT: begin
					if (emit) begin
						if (last_pt) begin
							oct_q <= '0;
							if (!job_pop) begin
								state_q <= BK_IDLE;
							end
						end else begin
							oct_q <= oct_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	// Job operands held while its points go out.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cx_q  <= job_cx;
			cy_q  <= job_cy;
			x_q   <= job_x;
			y_q   <= job_y;
			fin_q <= job_fin;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			if (fin_q) begin
				pixel_x      <= '0;
				pixel_y      <= '0;
				pixel_color  <= '0;
				pixel_valid  <= 1'b0;
				last_of_step <= 1'b1;
				finished     <= 1'b1;
			end else begin
				pixel_x      <= px;
				pixel_y      <= py;
				pixel_color  <= color;
				pixel_valid  <= 1'b1;
				last_of_step <= last_pt;
				finished     <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/midpoint_circle_rasterizer.sv */
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Bresenham midpoint circle outline generator with a queued point emitter.
// ----------------------------------------------------------------------------
// A start command produces the eight mirrored points of the first octant
// position, and each step command runs one midpoint iteration and produces
// eight more; a step after the outline has closed produces one status
// transfer with finished set. Points leave through a registered output at
// one transfer per cycle when the output is never stalled. The front end
// updates the decision in the cycle a command is accepted and places a job
// in a two-entry queue; when the emitter is idle the first point passes
// through the queue entry, the job operand registers and the output
// register before it is presented.
// The outline color may be written only while the block is idle.
`default_nettype none

module midpoint_circle_rasterizer #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     outline_color_we,
	input  wire logic [31:0]              outline_color,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     command,
	input  wire logic [COORD_BITS-1:0]    center_x,
	input  wire logic [COORD_BITS-1:0]    center_y,
	input  wire logic [COORD_BITS-1:0]    radius,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [COORD_BITS+1:0]  pixel_x,
	output logic signed [COORD_BITS+1:0]  pixel_y,
	output logic [31:0]                   pixel_color,
	output logic                          pixel_valid,
	output logic                          last_of_step,
	output logic                          finished
);

	localparam int JOB_BITS = 2 * COORD_BITS + 2 * (COORD_BITS + 1) + 1;

	logic [31:0]                color_q;
	logic                       f_push;
	logic                       q_not_full;
	logic                       q_not_empty;
	logic                       b_pop;
	logic [COORD_BITS-1:0]      f_cx;
	logic [COORD_BITS-1:0]      f_cy;
	logic signed [COORD_BITS:0] f_x;
	logic signed [COORD_BITS:0] f_y;
	logic                       f_fin;
	logic [JOB_BITS-1:0]        push_job;
	logic [JOB_BITS-1:0]        pop_job;

	// Outline color register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= mcr_pkg::COLOR_RESET;
		end else if (outline_color_we) begin
			color_q <= outline_color;
		end
	end

	mcr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.job_ready (q_not_full),
		.job_push  (f_push),
		.job_cx    (f_cx),
		.job_cy    (f_cy),
		.job_x     (f_x),
		.job_y     (f_y),
		.job_fin   (f_fin)
	);

	assign push_job = {f_cx, f_cy, f_x, f_y, f_fin};

	mcr_fifo #(
		.WIDTH(JOB_BITS)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data (push_job),
		.not_full  (q_not_full),
		.pop       (b_pop),
		.pop_data  (pop_job),
		.not_empty (q_not_empty)
	);

	mcr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_avail    (q_not_empty),
		.job_pop      (b_pop),
		.job_cx       (pop_job[JOB_BITS-1 -: COORD_BITS]),
		.job_cy       (pop_job[JOB_BITS-COORD_BITS-1 -: COORD_BITS]),
		.job_x        (pop_job[2*COORD_BITS+2 -: COORD_BITS+1]),
		.job_y        (pop_job[COORD_BITS+1 -: COORD_BITS+1]),
		.job_fin      (pop_job[0]),
		.color        (color_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.pixel_valid  (pixel_valid),
		.last_of_step (last_of_step),
		.finished     (finished)
	);

endmodule

`default_nettype wire
